// File: hw/rtl/ftrf_pkg.sv
// Shared constants, types and the checksum fold helper function of the TCP receive filter.
package ftrf_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int BIDX_W = $clog2(MAX_PACKET_BYTES + 2);
    localparam int DLEN_W = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SERVER_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_PORT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FREEZE_SEQUENCE = 2'd2;

    localparam logic [2:0] VERDICT_OK = 3'd0;
    localparam logic [2:0] VERDICT_SHORT = 3'd1;
    localparam logic [2:0] VERDICT_NOT_TCP = 3'd2;
    localparam logic [2:0] VERDICT_PORT = 3'd3;
    localparam logic [2:0] VERDICT_HANDSHAKE = 3'd4;
    localparam logic [2:0] VERDICT_TCP_SUM = 3'd5;
    localparam logic [2:0] VERDICT_DATA_SUM = 3'd6;
    localparam logic [2:0] VERDICT_LONG = 3'd7;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_SEND_SYNACK = 2'd1;
    localparam logic [1:0] REPLY_SEND_ACK = 2'd2;

    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_SYNC = 2'd1;
    localparam logic [1:0] ACK_LOAD = 2'd2;

    localparam logic [7:0] IP_PROTO_TCP = 8'd6;
    localparam logic [7:0] FLAG_MASK = 8'h1a;
    localparam logic [7:0] FLAGS_SYN = 8'h02;
    localparam logic [7:0] FLAGS_SYN_ACK = 8'h12;

    typedef struct packed {
        logic        server_mode;
        logic [15:0] local_port;
        logic        freeze_sequence;
    } cfg_t;

    typedef struct packed {
        logic              has_data;
        logic [7:0]        data_byte;
        logic              has_verdict;
        logic [2:0]        verdict;
        logic [1:0]        reply_kind;
        logic [31:0]       peer_addr;
        logic [15:0]       peer_port;
        logic [DLEN_W-1:0] data_length;
        logic [1:0]        ack_mode;
        logic [31:0]       new_ack;
    } event_t;

    function automatic logic [15:0] fold_not(input logic [31:0] s);
        logic [16:0] a;
        logic [16:0] c;
        a = {1'b0, s[31:16]} + {1'b0, s[15:0]};
        c = a + {16'd0, a[16]};
        return ~c[15:0];
    endfunction

endpackage

// File: hw/rtl/ftrf_if.sv
// Channel interfaces for datagram bytes in and filter results out.
interface ftrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       end_of_packet;

    modport source (output valid, output pkt_byte, output end_of_packet, input ready);
    modport sink (input valid, input pkt_byte, input end_of_packet, output ready);
endinterface

interface ftrf_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  verdict;
    logic [1:0]  reply_kind;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [11:0] data_length;
    logic [31:0] ack_number;
    logic [31:0] seq_number;
    logic        run_last;

    modport source (output valid, output kind, output data_byte, output verdict,
                    output reply_kind, output peer_addr, output peer_port,
                    output data_length, output ack_number, output seq_number,
                    output run_last, input ready);
    modport sink (input valid, input kind, input data_byte, input verdict,
                  input reply_kind, input peer_addr, input peer_port,
                  input data_length, input ack_number, input seq_number,
                  input run_last, output ready);
endinterface

// File: hw/rtl/ftrf_front.sv
// Front end: parses datagram bytes, accumulates checksums and classifies each packet.
module ftrf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  ftrf_pkg::cfg_t    cfg,
    ftrf_in_if.sink           pkt,
    input  logic              q_full,
    output logic              q_push,
    output ftrf_pkg::event_t  q_data
);
    import ftrf_pkg::*;

    logic [BIDX_W-1:0] byte_index_reg, byte_index_next;
    logic [5:0]  ip_hlen_reg, ip_hlen_next;
    logic [5:0]  tcp_hlen_reg, tcp_hlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [31:0] ports_reg, ports_next;
    logic [31:0] peer_seq_reg, peer_seq_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] tcp_sum_reg, tcp_sum_next;
    logic [15:0] data_sum_reg, data_sum_next;
    logic [31:0] tcp_acc_reg, tcp_acc_next;
    logic [31:0] data_acc_reg, data_acc_next;
    logic [7:0]  hold_reg, hold_next;

    logic              accept;
    logic              is_data;
    logic [7:0]        b;
    logic [BIDX_W-1:0] i;
    logic [BIDX_W-1:0] ih_old;
    logic [BIDX_W-1:0] th_old;
    logic [BIDX_W-1:0] o;
    logic [15:0]       word;
    logic              tcp_zone;
    logic [BIDX_W-1:0] size;
    logic [BIDX_W-1:0] ih;
    logic [BIDX_W-1:0] th;
    logic [BIDX_W-1:0] eff;
    logic [BIDX_W-1:0] hdrs;
    logic [BIDX_W-1:0] tl;
    logic              odd;
    logic [31:0]       tsum;
    logic [31:0]       dsum;
    logic              tcp_ok;
    logic              hs_srv;
    logic              hs_cli;
    logic [2:0]        verdict;
    logic [1:0]        reply;
    logic [1:0]        ack_mode;
    logic [BIDX_W-1:0] dlen;

    assign pkt.ready = !q_full;
    assign accept = pkt.valid && !q_full;
    assign b = pkt.pkt_byte;
    assign i = byte_index_reg;
    assign ih_old = BIDX_W'(ip_hlen_reg);
    assign th_old = BIDX_W'(tcp_hlen_reg);
    assign o = i - ih_old;
    assign word = {hold_reg, b};
    assign tcp_zone = (i != '0) && (ih_old >= BIDX_W'(20)) && (i >= ih_old);

    always_comb
    begin
        ip_hlen_next = ip_hlen_reg;
        tcp_hlen_next = tcp_hlen_reg;
        proto_next = proto_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        ports_next = ports_reg;
        peer_seq_next = peer_seq_reg;
        flags_next = flags_reg;
        tcp_sum_next = tcp_sum_reg;
        data_sum_next = data_sum_reg;
        tcp_acc_next = tcp_acc_reg;
        data_acc_next = data_acc_reg;
        hold_next = hold_reg;
        is_data = 1'b0;
        if (i < BIDX_W'(MAX_PACKET_BYTES))
        begin
            if (i == '0)
            begin
                ip_hlen_next = {b[3:0], 2'b00};
            end
            else if (i == BIDX_W'(9))
            begin
                proto_next = b;
            end
            else if (i >= BIDX_W'(12) && i <= BIDX_W'(15))
            begin
                src_next = {src_reg[23:0], b};
            end
            else if (i >= BIDX_W'(16) && i <= BIDX_W'(19))
            begin
                dst_next = {dst_reg[23:0], b};
            end
            // The pseudo-header address words are summed as they arrive.
            if (i == BIDX_W'(13) || i == BIDX_W'(15) || i == BIDX_W'(17)
                || i == BIDX_W'(19))
            begin
                tcp_acc_next = tcp_acc_reg + 32'(word);
            end
            if (tcp_zone)
            begin
                if (o <= BIDX_W'(3))
                begin
                    ports_next = {ports_reg[23:0], b};
                end
                else if (o <= BIDX_W'(7))
                begin
                    peer_seq_next = {peer_seq_reg[23:0], b};
                end
                else if (o == BIDX_W'(12))
                begin
                    tcp_hlen_next = {b[7:4], 2'b00};
                end
                else if (o == BIDX_W'(13))
                begin
                    flags_next = b;
                end
                else if (o == BIDX_W'(16))
                begin
                    tcp_sum_next = {b, 8'd0};
                end
                else if (o == BIDX_W'(17))
                begin
                    tcp_sum_next = {tcp_sum_reg[15:8], b};
                end
                if (i[0] && o != BIDX_W'(17))
                begin
                    tcp_acc_next = tcp_acc_reg + 32'(word);
                end
                if (th_old >= BIDX_W'(20))
                begin
                    if (o == th_old)
                    begin
                        data_sum_next = {b, 8'd0};
                    end
                    else if (o == th_old + BIDX_W'(1))
                    begin
                        data_sum_next = {data_sum_reg[15:8], b};
                    end
                    if (o >= th_old + BIDX_W'(4))
                    begin
                        is_data = 1'b1;
                        if (i[0] && o >= th_old + BIDX_W'(5))
                        begin
                            data_acc_next = data_acc_reg + 32'(word);
                        end
                    end
                end
            end
            if (!i[0])
            begin
                hold_next = b;
            end
        end
    end

    assign size = (i <= BIDX_W'(MAX_PACKET_BYTES)) ? i + BIDX_W'(1) : i;
    assign ih = BIDX_W'(ip_hlen_next);
    assign th = BIDX_W'(tcp_hlen_next);
    assign eff = (size > BIDX_W'(MAX_PACKET_BYTES)) ? BIDX_W'(MAX_PACKET_BYTES) : size;
    assign hdrs = ih + th + BIDX_W'(4);
    assign dlen = (ih >= BIDX_W'(20) && th >= BIDX_W'(20) && eff > hdrs) ? eff - hdrs : '0;
    assign tl = size - ih;
    assign odd = size[0];
    assign tsum = tcp_acc_next + 32'(tl) + (odd ? {16'd0, hold_next, 8'd0} : 32'd0);
    assign dsum = data_acc_next
                  + ((odd && (tl - BIDX_W'(1)) >= th + BIDX_W'(4))
                     ? {16'd0, hold_next, 8'd0} : 32'd0);
    assign tcp_ok = (fold_not(tsum) == tcp_sum_next);
    assign hs_srv = cfg.server_mode && ((flags_next & FLAG_MASK) == FLAGS_SYN);
    assign hs_cli = !cfg.server_mode && ((flags_next & FLAG_MASK) == FLAGS_SYN_ACK);

    always_comb
    begin
        reply = REPLY_NONE;
        ack_mode = ACK_KEEP;
        if (size > BIDX_W'(MAX_PACKET_BYTES))
        begin
            verdict = VERDICT_LONG;
        end
        else if (size < BIDX_W'(40))
        begin
            verdict = VERDICT_SHORT;
        end
        else if (proto_next != IP_PROTO_TCP)
        begin
            verdict = VERDICT_NOT_TCP;
        end
        else if (ih < BIDX_W'(20) || ih + BIDX_W'(20) > size)
        begin
            verdict = VERDICT_SHORT;
        end
        else if (ports_next[15:0] != cfg.local_port)
        begin
            verdict = VERDICT_PORT;
        end
        else if (hs_srv || hs_cli)
        begin
            verdict = VERDICT_HANDSHAKE;
            reply = hs_srv ? REPLY_SEND_SYNACK : REPLY_SEND_ACK;
            ack_mode = ACK_SYNC;
        end
        else if (th < BIDX_W'(20) || hdrs > size)
        begin
            verdict = VERDICT_SHORT;
        end
        else if (!tcp_ok)
        begin
            verdict = VERDICT_TCP_SUM;
        end
        else
        begin
            ack_mode = cfg.freeze_sequence ? ACK_KEEP : ACK_LOAD;
            verdict = (fold_not(dsum) != data_sum_next) ? VERDICT_DATA_SUM : VERDICT_OK;
        end
    end

    assign q_push = accept && (is_data || pkt.end_of_packet);

    always_comb
    begin
        q_data.has_data = is_data;
        q_data.data_byte = b;
        q_data.has_verdict = pkt.end_of_packet;
        q_data.verdict = verdict;
        q_data.reply_kind = reply;
        q_data.peer_addr = src_next;
        q_data.peer_port = ports_next[31:16];
        q_data.data_length = DLEN_W'(dlen);
        q_data.ack_mode = ack_mode;
        q_data.new_ack = peer_seq_next + 32'(tl - th);
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (accept)
        begin
            byte_index_next = pkt.end_of_packet ? '0 : size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            ip_hlen_reg <= '0;
            tcp_hlen_reg <= '0;
            proto_reg <= '0;
            src_reg <= '0;
            dst_reg <= '0;
            ports_reg <= '0;
            peer_seq_reg <= '0;
            flags_reg <= '0;
            tcp_sum_reg <= '0;
            data_sum_reg <= '0;
            tcp_acc_reg <= 32'(IP_PROTO_TCP);
            data_acc_reg <= '0;
            hold_reg <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            if (accept && pkt.end_of_packet)
            begin
                // The next packet starts from cleared header state.
                ip_hlen_reg <= '0;
                tcp_hlen_reg <= '0;
                proto_reg <= '0;
                src_reg <= '0;
                dst_reg <= '0;
                ports_reg <= '0;
                peer_seq_reg <= '0;
                flags_reg <= '0;
                tcp_sum_reg <= '0;
                data_sum_reg <= '0;
                tcp_acc_reg <= 32'(IP_PROTO_TCP);
                data_acc_reg <= '0;
                hold_reg <= '0;
            end
            else if (accept)
            begin
                ip_hlen_reg <= ip_hlen_next;
                tcp_hlen_reg <= tcp_hlen_next;
                proto_reg <= proto_next;
                src_reg <= src_next;
                dst_reg <= dst_next;
                ports_reg <= ports_next;
                peer_seq_reg <= peer_seq_next;
                flags_reg <= flags_next;
                tcp_sum_reg <= tcp_sum_next;
                data_sum_reg <= data_sum_next;
                tcp_acc_reg <= tcp_acc_next;
                data_acc_reg <= data_acc_next;
                hold_reg <= hold_next;
            end
        end
    end

endmodule

// File: hw/rtl/ftrf_queue.sv
// Short event queue that decouples the front end from the result stage.
module ftrf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ftrf_pkg::event_t  push_data,
    input  logic              pop,
    output ftrf_pkg::event_t  head,
    output logic              full,
    output logic              empty
);
    import ftrf_pkg::*;

    event_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/ftrf_back.sv
// Result stage: keeps the local sequence state and emits data and verdict results.
module ftrf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ftrf_pkg::event_t  head,
    input  logic              empty,
    output logic              pop,
    ftrf_out_if.source        res
);
    import ftrf_pkg::*;

    logic        valid_reg, valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  data_byte_reg, data_byte_next;
    logic [2:0]  verdict_reg, verdict_next;
    logic [1:0]  reply_reg, reply_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] port_reg, port_next;
    logic [11:0] dlen_reg, dlen_next;
    logic [31:0] ack_out_reg, ack_out_next;
    logic [31:0] seq_out_reg, seq_out_next;
    logic        last_reg, last_next;
    logic        data_done_reg, data_done_next;
    logic [31:0] local_seq_reg, local_seq_next;
    logic [31:0] local_ack_reg, local_ack_next;
    logic        can_load;

    assign can_load = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg && !res.ready;
        kind_next = kind_reg;
        data_byte_next = data_byte_reg;
        verdict_next = verdict_reg;
        reply_next = reply_reg;
        addr_next = addr_reg;
        port_next = port_reg;
        dlen_next = dlen_reg;
        ack_out_next = ack_out_reg;
        seq_out_next = seq_out_reg;
        last_next = last_reg;
        data_done_next = data_done_reg;
        local_seq_next = local_seq_reg;
        local_ack_next = local_ack_reg;
        pop = 1'b0;
        if (can_load && !empty)
        begin
            valid_next = 1'b1;
            if (head.has_data && !data_done_reg)
            begin
                kind_next = 1'b0;
                data_byte_next = head.data_byte;
                verdict_next = VERDICT_OK;
                reply_next = REPLY_NONE;
                addr_next = '0;
                port_next = '0;
                dlen_next = '0;
                ack_out_next = '0;
                seq_out_next = '0;
                last_next = 1'b0;
                if (head.has_verdict)
                begin
                    data_done_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                unique case (head.ack_mode)
                    ACK_SYNC:
                    begin
                        local_seq_next = 32'd1;
                        local_ack_next = 32'd1;
                    end
                    ACK_LOAD:
                    begin
                        local_ack_next = head.new_ack;
                    end
                    default:
                    begin
                    end
                endcase
                kind_next = 1'b1;
                data_byte_next = '0;
                verdict_next = head.verdict;
                reply_next = head.reply_kind;
                addr_next = head.peer_addr;
                port_next = head.peer_port;
                dlen_next = head.data_length;
                ack_out_next = local_ack_next;
                seq_out_next = local_seq_next;
                last_next = 1'b1;
                data_done_next = 1'b0;
                pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_byte_reg <= data_byte_next;
        verdict_reg <= verdict_next;
        reply_reg <= reply_next;
        addr_reg <= addr_next;
        port_reg <= port_next;
        dlen_reg <= dlen_next;
        ack_out_reg <= ack_out_next;
        seq_out_reg <= seq_out_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_done_reg <= 1'b0;
            local_seq_reg <= '0;
            local_ack_reg <= 32'd1;
        end
        else
        begin
            valid_reg <= valid_next;
            data_done_reg <= data_done_next;
            local_seq_reg <= local_seq_next;
            local_ack_reg <= local_ack_next;
        end
    end

    assign res.valid = valid_reg;
    assign res.kind = kind_reg;
    assign res.data_byte = data_byte_reg;
    assign res.verdict = verdict_reg;
    assign res.reply_kind = reply_reg;
    assign res.peer_addr = addr_reg;
    assign res.peer_port = port_reg;
    assign res.data_length = dlen_reg;
    assign res.ack_number = ack_out_reg;
    assign res.seq_number = seq_out_reg;
    assign res.run_last = last_reg;

endmodule

// File: hw/rtl/fake_tcp_receive_filter.sv
// Top level of the TCP receive filter: configuration registers, front end, queue, result stage.
// A data byte or verdict result is registered in the event queue, then in the output register.
// One byte is accepted per cycle unless the queue is full; a final data byte gives two results.
// The four-entry event queue absorbs those extra results and output stalls.
// Reset clears all packet state and configuration, sets the sequence number to 0 and ack to 1.
module fake_tcp_receive_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    ftrf_in_if.sink                          pkt,
    ftrf_out_if.source                       res,
    input  logic                             cfg_wr_en,
    input  logic [ftrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ftrf_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import ftrf_pkg::*;

    cfg_t   cfg_reg;
    event_t q_in;
    event_t q_head;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SERVER_MODE:     cfg_reg.server_mode <= cfg_wr_data[0];
                CFG_LOCAL_PORT:      cfg_reg.local_port <= cfg_wr_data;
                CFG_FREEZE_SEQUENCE: cfg_reg.freeze_sequence <= cfg_wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    ftrf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pkt    (pkt),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    ftrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    ftrf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .empty (q_empty),
        .pop   (q_pop),
        .res   (res)
    );

endmodule

// File: verif/fake_tcp_receive_filter_tb.sv
// Testbench of the TCP receive filter: builds datagrams, predicts every result and checks it.
`timescale 1ns / 100ps

module fake_tcp_receive_filter_tb;
    import ftrf_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SPOIL_NONE = 0;
    localparam int SPOIL_TCP_SUM = 1;
    localparam int SPOIL_DATA_SUM = 2;

    typedef struct {
        logic [7:0] b;
        logic       eop;
    } wire_byte_t;

    typedef struct {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  verdict;
        logic [1:0]  reply_kind;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [11:0] data_length;
        logic [31:0] ack_number;
        logic [31:0] seq_number;
        logic        run_last;
    } filter_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    ftrf_in_if pkt_ch();
    ftrf_out_if res_ch();

    fake_tcp_receive_filter DUT (
        .clk(clk),
        .rst_n(rst_n),
        .pkt(pkt_ch.sink),
        .res(res_ch.source),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    wire_byte_t pending_bytes[$];
    filter_result_t expected_results[$];
    int errors = 0;
    int bytes_sent = 0;
    int packets_seen = 0;
    int verdict_count[8];
    int send_gap = 0;
    int recv_gap = 0;
    int idle_cycles = 0;

    // Mirror of the filter state.
    logic        mode_server = 0;
    logic [15:0] port_local = 0;
    logic        ack_frozen = 0;
    int          pos = 0;
    int          ihl_bytes;
    int          thl_bytes;
    logic [7:0]  proto_r;
    logic [31:0] src_r;
    logic [31:0] dst_r;
    logic [31:0] ports_r;
    logic [31:0] peer_seq_r;
    logic [7:0]  flags_r;
    logic [15:0] tcp_sum_r;
    logic [15:0] data_sum_r;
    logic [31:0] tcp_acc;
    logic [31:0] data_acc;
    logic [7:0]  hold_r;
    logic [31:0] seq_local = 0;
    logic [31:0] ack_local = 1;

    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        logic [31:0] t;
        t = (s >> 16) + (s & 32'hffff);
        t = t + (t >> 16);
        return ~t[15:0];
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic eop);
        int ih;
        int th;
        int o;
        int size;
        int eff;
        int tl;
        bit is_data;
        bit odd;
        logic [31:0] s;
        logic [31:0] d;
        filter_result_t r;
        if (pos == 0) begin
            ihl_bytes = 0; thl_bytes = 0; proto_r = 0; src_r = 0; dst_r = 0;
            ports_r = 0; peer_seq_r = 0; flags_r = 0; tcp_sum_r = 0; data_sum_r = 0;
            tcp_acc = 0; data_acc = 0; hold_r = 0;
        end
        if (pos < MAX_PACKET_BYTES) begin
            is_data = 0;
            ih = ihl_bytes;
            if (pos == 0) ihl_bytes = b[3:0] * 4;
            else if (pos == 9) proto_r = b;
            else if (pos >= 12 && pos <= 15) src_r = {src_r[23:0], b};
            else if (pos >= 16 && pos <= 19) dst_r = {dst_r[23:0], b};
            if (pos != 0 && ih >= 20 && pos >= ih) begin
                o = pos - ih;
                th = thl_bytes;
                if (o <= 3) ports_r = {ports_r[23:0], b};
                else if (o <= 7) peer_seq_r = {peer_seq_r[23:0], b};
                else if (o == 12) thl_bytes = b[7:4] * 4;
                else if (o == 13) flags_r = b;
                else if (o == 16) tcp_sum_r = {b, 8'h00};
                else if (o == 17) tcp_sum_r[7:0] = b;
                if (pos[0] && o != 17) tcp_acc += {16'h0, hold_r, b};
                if (th >= 20) begin
                    if (o == th) data_sum_r = {b, 8'h00};
                    else if (o == th + 1) data_sum_r[7:0] = b;
                    if (o >= th + 4) begin
                        is_data = 1;
                        if (pos[0] && o >= th + 5) data_acc += {16'h0, hold_r, b};
                    end
                end
            end
            if (!pos[0]) hold_r = b;
            if (is_data) begin
                r = '{1'b0, b, 3'd0, 2'd0, 32'd0, 16'd0, 12'd0, 32'd0, 32'd0, 1'b0};
                expected_results.push_back(r);
            end
        end
        if (pos <= MAX_PACKET_BYTES) pos++;
        if (eop) begin
            size = pos;
            ih = ihl_bytes;
            th = thl_bytes;
            eff = (size > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : size;
            r = '{1'b1, 8'd0, VERDICT_OK, REPLY_NONE, src_r, ports_r[31:16], 12'd0,
                  32'd0, 32'd0, 1'b1};
            if (ih >= 20 && th >= 20 && eff > ih + th + 4)
                r.data_length = 12'(eff - (ih + th + 4));
            if (size > MAX_PACKET_BYTES) r.verdict = VERDICT_LONG;
            else if (size < 40) r.verdict = VERDICT_SHORT;
            else if (proto_r != IP_PROTO_TCP) r.verdict = VERDICT_NOT_TCP;
            else if (ih < 20 || ih + 20 > size) r.verdict = VERDICT_SHORT;
            else if (ports_r[15:0] != port_local) r.verdict = VERDICT_PORT;
            else if (mode_server && (flags_r & FLAG_MASK) == FLAGS_SYN) begin
                seq_local = 1; ack_local = 1;
                r.reply_kind = REPLY_SEND_SYNACK; r.verdict = VERDICT_HANDSHAKE;
            end else if (!mode_server && (flags_r & FLAG_MASK) == FLAGS_SYN_ACK) begin
                seq_local = 1; ack_local = 1;
                r.reply_kind = REPLY_SEND_ACK; r.verdict = VERDICT_HANDSHAKE;
            end else if (th < 20 || ih + th + 4 > size) r.verdict = VERDICT_SHORT;
            else begin
                tl = size - ih;
                odd = size[0];
                s = tcp_acc + (src_r >> 16) + (src_r & 32'hffff) + (dst_r >> 16)
                    + (dst_r & 32'hffff) + 6 + tl;
                if (odd) s += {16'h0, hold_r, 8'h00};
                if (ones_fold(s) != tcp_sum_r) r.verdict = VERDICT_TCP_SUM;
                else begin
                    d = data_acc;
                    if (!ack_frozen) ack_local = peer_seq_r + (tl - th);
                    if (odd && tl - 1 >= th + 4) d += {16'h0, hold_r, 8'h00};
                    r.verdict = (ones_fold(d) != data_sum_r) ? VERDICT_DATA_SUM : VERDICT_OK;
                end
            end
            r.ack_number = ack_local;
            r.seq_number = seq_local;
            expected_results.push_back(r);
            pos = 0;
        end
    endtask

    // Builds one datagram; header fields out of range keep the layout of a minimal header.
    task automatic queue_packet(input logic [7:0] proto, input int ihl, input int doff,
                                input logic [7:0] flags, input logic [15:0] dport,
                                input int plen, input int spoil, input int cut);
        logic [7:0] pk[];
        int ih;
        int th;
        int n;
        int k;
        logic [31:0] s;
        logic [15:0] f;
        wire_byte_t w;
        ih = (ihl < 5) ? 20 : ihl * 4;
        th = (doff < 5) ? 20 : doff * 4;
        n = ih + th + 4 + plen;
        pk = new[n];
        for (k = 0; k < n; k++) pk[k] = $urandom_range(0, 255);
        pk[0] = {4'h4, ihl[3:0]};
        pk[9] = proto;
        pk[ih + 2] = dport[15:8];
        pk[ih + 3] = dport[7:0];
        pk[ih + 12][7:4] = doff[3:0];
        pk[ih + 13] = flags;
        s = 0;
        for (k = ih + th + 4; k < n; k += 2) s += {pk[k], (k + 1 < n) ? pk[k + 1] : 8'h00};
        f = ones_fold(s) ^ ((spoil == SPOIL_DATA_SUM) ? 16'h0001 << $urandom_range(0, 15) : 16'h0);
        pk[ih + th] = f[15:8];
        pk[ih + th + 1] = f[7:0];
        pk[ih + 16] = 0;
        pk[ih + 17] = 0;
        s = {pk[12], pk[13]} + {pk[14], pk[15]} + {pk[16], pk[17]} + {pk[18], pk[19]}
            + 6 + (n - ih);
        for (k = ih; k < n; k += 2) s += {pk[k], (k + 1 < n) ? pk[k + 1] : 8'h00};
        f = ones_fold(s) ^ ((spoil == SPOIL_TCP_SUM) ? 16'h0001 << $urandom_range(0, 15) : 16'h0);
        pk[ih + 16] = f[15:8];
        pk[ih + 17] = f[7:0];
        if (cut > 0 && cut < n) n = cut;
        for (k = 0; k < n; k++) begin
            w.b = pk[k];
            w.eop = (k == n - 1);
            pending_bytes.push_back(w);
        end
    endtask

    task automatic queue_noise();
        int n;
        int k;
        wire_byte_t w;
        n = $urandom_range(1, 70);
        for (k = 0; k < n; k++) begin
            w.b = $urandom_range(0, 255);
            w.eop = (k == n - 1);
            pending_bytes.push_back(w);
        end
    endtask

    function automatic logic [7:0] open_flags(input bit syn_ack);
        logic [7:0] f;
        f = $urandom_range(0, 255);
        f = (f & ~FLAG_MASK) | (syn_ack ? FLAGS_SYN_ACK : FLAGS_SYN);
        return f;
    endfunction

    task automatic queue_random_packet();
        int pick;
        int plen;
        logic [7:0] flags;
        pick = $urandom_range(0, 19);
        plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 24);
        flags = $urandom_range(0, 255);
        case (pick)
            0: queue_noise();
            1: queue_packet($urandom_range(0, 255), $urandom_range(5, 7), $urandom_range(5, 8),
                            flags, port_local, plen, SPOIL_NONE, 0);
            2: queue_packet(IP_PROTO_TCP, $urandom_range(5, 7), $urandom_range(5, 8), flags,
                            $urandom_range(0, 65535), plen, SPOIL_NONE, 0);
            3: queue_packet(IP_PROTO_TCP, 5, $urandom_range(5, 8), flags, port_local, plen,
                            SPOIL_TCP_SUM, 0);
            4: queue_packet(IP_PROTO_TCP, $urandom_range(5, 7), 5, flags, port_local, plen,
                            SPOIL_DATA_SUM, 0);
            5: queue_packet(IP_PROTO_TCP, $urandom_range(5, 15), $urandom_range(5, 15), flags,
                            port_local, plen, SPOIL_NONE, $urandom_range(1, 80));
            6, 7: queue_packet(IP_PROTO_TCP, $urandom_range(5, 7), $urandom_range(0, 8),
                               open_flags($urandom_range(0, 1)), port_local, plen,
                               SPOIL_NONE, 0);
            8: queue_packet(IP_PROTO_TCP, $urandom_range(0, 15), $urandom_range(0, 15), flags,
                            port_local, plen, SPOIL_NONE, 0);
            default: queue_packet(IP_PROTO_TCP, $urandom_range(5, 7), $urandom_range(5, 8),
                                  flags, port_local, plen, SPOIL_NONE, 0);
        endcase
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        if (idx == CFG_SERVER_MODE) mode_server = val[0];
        else if (idx == CFG_LOCAL_PORT) port_local = val;
        else if (idx == CFG_FREEZE_SEQUENCE) ack_frozen = val[0];
    endtask

    task automatic set_config(input logic srv, input logic [15:0] port, input logic frz);
        wait (pending_bytes.size() == 0 && !pkt_ch.valid && expected_results.size() == 0);
        repeat (8) @(posedge clk);
        write_reg(CFG_SERVER_MODE, {15'd0, srv});
        write_reg(CFG_LOCAL_PORT, port);
        write_reg(CFG_FREEZE_SEQUENCE, {15'd0, frz});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pkt_ch.valid <= 1'b0;
            pkt_ch.pkt_byte <= 8'd0;
            pkt_ch.end_of_packet <= 1'b0;
            send_gap <= pick_gap();
        end else begin
            if (pkt_ch.valid && pkt_ch.ready) begin
                predict_byte(pkt_ch.pkt_byte, pkt_ch.end_of_packet);
                bytes_sent++;
            end
            if (!pkt_ch.valid || pkt_ch.ready) begin
                if (send_gap > 0 || pending_bytes.size() == 0) begin
                    pkt_ch.valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    pkt_ch.valid <= 1'b1;
                    pkt_ch.pkt_byte <= pending_bytes[0].b;
                    pkt_ch.end_of_packet <= pending_bytes[0].eop;
                    void'(pending_bytes.pop_front());
                    send_gap <= pick_gap();
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t e;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            recv_gap <= pick_gap();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction, kind %0d", res_ch.kind);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (res_ch.kind !== e.kind) begin
                        $error("kind: expected %0h actual %0h", e.kind, res_ch.kind);
                        errors++;
                    end
                    if (res_ch.data_byte !== e.data_byte) begin
                        $error("data_byte: expected %0h actual %0h", e.data_byte, res_ch.data_byte);
                        errors++;
                    end
                    if (res_ch.verdict !== e.verdict) begin
                        $error("verdict: expected %0h actual %0h", e.verdict, res_ch.verdict);
                        errors++;
                    end
                    if (res_ch.reply_kind !== e.reply_kind) begin
                        $error("reply_kind: expected %0h actual %0h", e.reply_kind,
                               res_ch.reply_kind);
                        errors++;
                    end
                    if (res_ch.peer_addr !== e.peer_addr) begin
                        $error("peer_addr: expected %0h actual %0h", e.peer_addr, res_ch.peer_addr);
                        errors++;
                    end
                    if (res_ch.peer_port !== e.peer_port) begin
                        $error("peer_port: expected %0h actual %0h", e.peer_port, res_ch.peer_port);
                        errors++;
                    end
                    if (res_ch.data_length !== e.data_length) begin
                        $error("data_length: expected %0h actual %0h", e.data_length,
                               res_ch.data_length);
                        errors++;
                    end
                    if (res_ch.ack_number !== e.ack_number) begin
                        $error("ack_number: expected %0h actual %0h", e.ack_number,
                               res_ch.ack_number);
                        errors++;
                    end
                    if (res_ch.seq_number !== e.seq_number) begin
                        $error("seq_number: expected %0h actual %0h", e.seq_number,
                               res_ch.seq_number);
                        errors++;
                    end
                    if (res_ch.run_last !== e.run_last) begin
                        $error("run_last: expected %0h actual %0h", e.run_last, res_ch.run_last);
                        errors++;
                    end
                    if (e.kind) begin
                        packets_seen++;
                        verdict_count[e.verdict]++;
                    end
                end
            end
            if (recv_gap > 0) begin
                res_ch.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                res_ch.ready <= 1'b1;
                if (res_ch.valid) recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        int budget;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        set_config(1'b0, 16'h1f90, 1'b0);
        queue_packet(IP_PROTO_TCP, 5, 5, 8'h18, 16'h1f90, 0, SPOIL_NONE, 0);
        queue_packet(IP_PROTO_TCP, 5, 5, 8'h18, 16'h1f90, 7, SPOIL_NONE, 0);
        queue_packet(IP_PROTO_TCP, 6, 8, 8'hff, 16'h1f90, 10, SPOIL_NONE, 0);
        queue_packet(IP_PROTO_TCP, 5, 5, open_flags(1), 16'h1f90, 3, SPOIL_NONE, 0);
        queue_packet(IP_PROTO_TCP, 5, 5, open_flags(0), 16'h1f90, 3, SPOIL_NONE, 0);
        queue_packet(8'd17, 5, 5, 8'h10, 16'h1f90, 2, SPOIL_NONE, 0);
        queue_packet(IP_PROTO_TCP, 5, 5, 8'h10, 16'h1f91, 2, SPOIL_NONE, 0);
        queue_packet(IP_PROTO_TCP, 5, 5, 8'h10, 16'h1f90, 2, SPOIL_NONE, 39);
        queue_packet(IP_PROTO_TCP, 4, 5, 8'h10, 16'h1f90, 2, SPOIL_NONE, 0);
        queue_packet(IP_PROTO_TCP, 15, 5, 8'h10, 16'h1f90, 0, SPOIL_NONE, 70);
        queue_packet(IP_PROTO_TCP, 5, 4, 8'h10, 16'h1f90, 2, SPOIL_NONE, 0);
        queue_packet(IP_PROTO_TCP, 5, 15, 8'h10, 16'h1f90, 2, SPOIL_NONE, 70);
        queue_packet(IP_PROTO_TCP, 5, 5, 8'h10, 16'h1f90, 9, SPOIL_TCP_SUM, 0);
        queue_packet(IP_PROTO_TCP, 5, 5, 8'h10, 16'h1f90, 9, SPOIL_DATA_SUM, 0);

        for (p = 0; p < 4; p++) begin
            case (p)
                0: set_config(1'b1, 16'hffff, 1'b1);
                1: set_config(1'b0, 16'h0000, 1'b1);
                2: set_config(1'b1, $urandom_range(0, 65535), 1'b0);
                default: set_config(1'b0, $urandom_range(0, 65535), 1'b0);
            endcase
            budget = bytes_sent + pending_bytes.size() + 200;
            while (bytes_sent + pending_bytes.size() < budget) begin
                queue_random_packet();
                wait (pending_bytes.size() < 200);
            end
        end

        wait (pending_bytes.size() == 0 && !pkt_ch.valid && expected_results.size() == 0);
        repeat (20) @(posedge clk);
        $display("Covered %0d packets in %0d bytes over five register settings.",
                 packets_seen, bytes_sent);
        $display("Verdict counts, codes 0 to 7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3],
                 verdict_count[4], verdict_count[5], verdict_count[6], verdict_count[7]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ftrf_pkg.sv
hw/rtl/ftrf_if.sv
hw/rtl/ftrf_front.sv
hw/rtl/ftrf_queue.sv
hw/rtl/ftrf_back.sv
hw/rtl/fake_tcp_receive_filter.sv
verif/fake_tcp_receive_filter_tb.sv
